// ===== rtl/core/tcce_pkg.sv =====
// tcce_pkg: shared types, codes and constants for the text console cursor engine
// used by tcce_front, tcce_queue, tcce_back and text_console_cursor_engine_core
// no dependencies
`default_nettype none

package tcce_pkg;

  // sizes
  localparam int COORD_BITS_DEFAULT  = 8;
  localparam int COORD_MAX_BITS      = 12;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int CFG_BITS            = 8;
  localparam int ADDR_BITS           = 16;
  localparam int CHAR_BITS           = 8;

  // register reset values
  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 8'd40;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 8'd25;

  // character codes and glyphs
  localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'h0d;
  localparam logic [CHAR_BITS-1:0] CHAR_LF    = 8'h0a;
  localparam logic [CHAR_BITS-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] GLYPH_BASE = 8'd136;
  localparam logic [3:0]           COLOR_LAST = 4'd15;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_DRAW   = 2'd1,
    OP_ERASE  = 2'd2,
    OP_RETURN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_SCROLL = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [CHAR_BITS-1:0] char_code;
  } in_item_t;

  typedef struct packed {
    kind_t                kind;
    logic [ADDR_BITS-1:0] address;
    logic [CHAR_BITS-1:0] data;
    logic                 last;
  } out_item_t;

  // work for the back end: an optional cell access, then an optional scroll
  typedef struct packed {
    logic                      first_valid;
    kind_t                     first_kind;
    logic [COORD_MAX_BITS-1:0] row;
    logic [COORD_MAX_BITS-1:0] column;
    logic [CHAR_BITS-1:0]      data;
    logic                      scroll;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcce_front.sv =====
// tcce_front: accepts items, keeps the write position, cursor, blink and saved
// character, and turns each item that needs one into a command for the back end
// depends on tcce_pkg
`default_nettype none

module tcce_front #(
  parameter int COORD_BITS = tcce_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_fire,
  input  wire tcce_pkg::in_item_t                 item,
  input  wire logic [tcce_pkg::CFG_BITS-1:0]      w,
  input  wire logic [tcce_pkg::CFG_BITS-1:0]      h,
  output tcce_pkg::cmd_t                          cmd,
  output logic                                    cmd_push
);

  localparam int EXT_BITS = ((COORD_BITS > tcce_pkg::CFG_BITS) ? COORD_BITS
                                                                : tcce_pkg::CFG_BITS) + 1;

  logic [COORD_BITS-1:0] column, column_next;
  logic [COORD_BITS-1:0] row, row_next;
  logic [COORD_BITS-1:0] cursor_column, cursor_column_next;
  logic [COORD_BITS-1:0] cursor_row, cursor_row_next;
  logic [3:0]            blink_color, blink_color_next;
  logic                  blink_phase, blink_phase_next;
  logic [tcce_pkg::CHAR_BITS-1:0] saved_char, saved_char_next;
  logic                  saved_valid, saved_valid_next;

  logic [EXT_BITS-1:0]   w_ext, h_ext, w_m1, h_m1, col_ext, col_inc;
  logic [3:0]            color_inc;
  logic [tcce_pkg::CHAR_BITS-1:0] ch;

  // width and height in a common compare width
  assign w_ext   = EXT_BITS'(w);
  assign h_ext   = EXT_BITS'(h);
  assign w_m1    = w_ext - 1'b1;
  assign h_m1    = h_ext - 1'b1;
  assign col_ext = EXT_BITS'(column);
  assign col_inc = col_ext + 1'b1;
  assign ch      = item.char_code;
  assign color_inc = blink_color + 1'b1;

  // item decode and position update
  always_comb begin
    column_next        = column;
    row_next           = row;
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    blink_color_next   = blink_color;
    blink_phase_next   = blink_phase;
    saved_char_next    = saved_char;
    saved_valid_next   = saved_valid;
    cmd                = '0;
    cmd.first_kind     = tcce_pkg::KIND_WRITE;

    unique case (tcce_pkg::op_t'(item.op))
      tcce_pkg::OP_PUT: begin
        priority if (ch == tcce_pkg::CHAR_CR) begin
          column_next = '0;
        end else if (ch == tcce_pkg::CHAR_LF) begin
          row_next = row + 1'b1;
        end else if (ch == tcce_pkg::CHAR_BS) begin
          // step back, wrapping to the end of the row above; top-left stays put
          if (column != '0) begin
            column_next = column - 1'b1;
          end else if (row != '0) begin
            row_next    = row - 1'b1;
            column_next = w_m1[COORD_BITS-1:0];
          end
          cmd.first_valid = 1'b1;
          cmd.first_kind  = tcce_pkg::KIND_READ;
          cmd.row         = tcce_pkg::COORD_MAX_BITS'(row_next);
          cmd.column      = tcce_pkg::COORD_MAX_BITS'(column_next);
        end else begin
          // printable: write here, advance and wrap at the width
          cmd.first_valid = 1'b1;
          cmd.first_kind  = tcce_pkg::KIND_WRITE;
          cmd.row         = tcce_pkg::COORD_MAX_BITS'(row);
          cmd.column      = tcce_pkg::COORD_MAX_BITS'(column);
          cmd.data        = ch;
          if (col_inc >= w_ext) begin
            column_next = '0;
            row_next    = row + 1'b1;
          end else begin
            column_next = col_inc[COORD_BITS-1:0];
          end
        end
        // scroll when the row has run off the bottom
        if (EXT_BITS'(row_next) >= h_ext) begin
          cmd.scroll  = 1'b1;
          row_next    = h_m1[COORD_BITS-1:0];
          column_next = '0;
        end
      end
      tcce_pkg::OP_DRAW: begin
        cmd.first_valid = 1'b1;
        cmd.first_kind  = tcce_pkg::KIND_WRITE;
        cmd.row         = tcce_pkg::COORD_MAX_BITS'(row);
        cmd.column      = tcce_pkg::COORD_MAX_BITS'(column);
        cmd.data        = tcce_pkg::GLYPH_BASE + {1'b0, blink_color, 3'b000};
        blink_phase_next = ~blink_phase;
        if (blink_phase) begin
          blink_color_next = (color_inc == tcce_pkg::COLOR_LAST) ? 4'd0 : color_inc;
        end
        if (col_ext >= w_ext) begin
          cursor_column_next = '0;
          cursor_row_next    = row + 1'b1;
        end else begin
          cursor_column_next = column;
          cursor_row_next    = row;
        end
      end
      tcce_pkg::OP_ERASE: begin
        cmd.first_valid = 1'b1;
        cmd.first_kind  = tcce_pkg::KIND_WRITE;
        cmd.row         = tcce_pkg::COORD_MAX_BITS'(cursor_row);
        cmd.column      = tcce_pkg::COORD_MAX_BITS'(cursor_column);
        cmd.data        = saved_valid ? saved_char : tcce_pkg::CHAR_SPACE;
      end
      tcce_pkg::OP_RETURN: begin
        saved_char_next  = ch;
        saved_valid_next = 1'b1;
      end
      default: begin
        saved_valid_next = saved_valid;
      end
    endcase

    cmd_push = in_fire && (cmd.first_valid || cmd.scroll);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column        <= '0;
      row           <= '0;
      cursor_column <= '0;
      cursor_row    <= '0;
      blink_color   <= '0;
      blink_phase   <= 1'b0;
      saved_char    <= '0;
      saved_valid   <= 1'b0;
    end else if (in_fire) begin
      column        <= column_next;
      row           <= row_next;
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
      blink_color   <= blink_color_next;
      blink_phase   <= blink_phase_next;
      saved_char    <= saved_char_next;
      saved_valid   <= saved_valid_next;
    end
  end

  // colour sequence skips the last colour
  a_color_range: assert property (@(posedge clk) disable iff (rst)
    blink_color != tcce_pkg::COLOR_LAST)
    else $error("blink colour reached the skipped value");

endmodule

`default_nettype wire

// ===== rtl/core/tcce_queue.sv =====
// tcce_queue: short command queue between front and back ends
// depends on tcce_pkg
`default_nettype none

module tcce_queue #(
  parameter int DEPTH = tcce_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire tcce_pkg::cmd_t wr_data,
  input  wire logic           rd_en,
  output tcce_pkg::cmd_t      rd_data,
  output logic                full,
  output logic                empty
);

  localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  tcce_pkg::cmd_t        entries [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [COUNT_BITS-1:0] count;
  logic                  do_wr, do_rd;

  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign full    = (count == COUNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(DEPTH))
    else $error("queue fill count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("command written into a full queue");

endmodule

`default_nettype wire

// ===== rtl/core/tcce_back.sv =====
// tcce_back: expands queued commands into results, forms row*width+column
// addresses and holds the result register
// depends on tcce_pkg
`default_nettype none

module tcce_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [tcce_pkg::CFG_BITS-1:0] w,
  input  wire tcce_pkg::cmd_t                head,
  input  wire logic                          q_empty,
  output logic                               q_pop,
  output tcce_pkg::out_item_t                result,
  output logic                               out_valid,
  input  wire logic                          pop
);

  localparam int PROD_BITS = tcce_pkg::COORD_MAX_BITS + tcce_pkg::CFG_BITS;

  logic                 sub, sub_next;
  logic                 advance;
  logic [PROD_BITS-1:0] prod;
  tcce_pkg::out_item_t  res_next;

  // load the result register when it is free or being taken
  assign advance = !q_empty && (!out_valid || (pop && out_valid));

  // cell address
  assign prod = PROD_BITS'(head.row) * PROD_BITS'(w) + PROD_BITS'(head.column);

  // pick the cell access first, then the scroll
  always_comb begin
    res_next = '0;
    sub_next = sub;
    q_pop    = 1'b0;
    if (head.first_valid && !sub) begin
      res_next.kind    = head.first_kind;
      res_next.address = prod[tcce_pkg::ADDR_BITS-1:0];
      res_next.data    = head.data;
      res_next.last    = !head.scroll;
      if (advance) begin
        q_pop    = !head.scroll;
        sub_next = head.scroll;
      end
    end else begin
      res_next.kind    = tcce_pkg::KIND_SCROLL;
      res_next.address = '0;
      res_next.data    = '0;
      res_next.last    = 1'b1;
      if (advance) begin
        q_pop    = 1'b1;
        sub_next = 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else begin
      sub <= sub_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_scroll_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.kind == tcce_pkg::KIND_SCROLL |-> result.last)
    else $error("scroll result not marked last");

  a_sub_has_head: assert property (@(posedge clk) disable iff (rst)
    sub |-> !q_empty && head.scroll)
    else $error("second half pending without a scrolling command");

endmodule

`default_nettype wire

// ===== rtl/core/text_console_cursor_engine_core.sv =====
// An accepted item's command is registered in the command queue, then each of its
// results in the result register; a second result (scroll) follows the first.
// Throughput: one item per cycle while the queue is not full; the back end gives
// one result per cycle while results are taken, with a QUEUE_DEPTH command queue between.
// Reset (synchronous, rst high): position, cursor, blink and saved character
// cleared, queue and result register emptied, registers back to 40 by 25.
`default_nettype none

module text_console_cursor_engine_core #(
  parameter int COORD_BITS  = tcce_pkg::COORD_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = tcce_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire tcce_pkg::in_item_t            item,
  output logic                               empty,
  input  wire logic                          pop,
  output tcce_pkg::out_item_t                result,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_index,
  input  wire logic [tcce_pkg::CFG_BITS-1:0] cfg_data
);

  localparam int CAP = (COORD_BITS >= tcce_pkg::CFG_BITS) ? 255 : (1 << COORD_BITS);

  logic [tcce_pkg::CFG_BITS-1:0] screen_width, screen_height;
  logic [tcce_pkg::CFG_BITS-1:0] w, h;
  logic                          in_fire, cmd_push, q_full, q_empty, q_pop, out_valid;
  tcce_pkg::cmd_t                cmd, head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= tcce_pkg::WIDTH_RESET;
      screen_height <= tcce_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (tcce_pkg::cfg_reg_t'(cfg_index))
        tcce_pkg::CFG_WIDTH:  screen_width  <= cfg_data;
        tcce_pkg::CFG_HEIGHT: screen_height <= cfg_data;
        default:              screen_width  <= screen_width;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the coordinate range
  assign w = (screen_width == '0) ? 8'd1 :
             (32'(screen_width) > CAP) ? tcce_pkg::CFG_BITS'(CAP) : screen_width;
  assign h = (screen_height == '0) ? 8'd1 :
             (32'(screen_height) > CAP) ? tcce_pkg::CFG_BITS'(CAP) : screen_height;

  // handshakes
  assign full    = q_full;
  assign in_fire = push && !q_full;
  assign empty   = !out_valid;

  tcce_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .item     (item),
    .w        (w),
    .h        (h),
    .cmd      (cmd),
    .cmd_push (cmd_push)
  );

  tcce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .rd_en   (q_pop),
    .rd_data (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  tcce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .w         (w),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .result    (result),
    .out_valid (out_valid),
    .pop       (pop)
  );

endmodule

`default_nettype wire
